/* rtl/box_blur_3x3_edge_average_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion forms for the blur block checkers.
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_EDGE_AVERAGE_DEFINES_SVH
`define BOX_BLUR_3X3_EDGE_AVERAGE_DEFINES_SVH

// checked outside reset only
`define BB3_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("bb3 assertion failed");

// checked in every cycle, reset included
`define BB3_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("bb3 assertion failed");

`endif

/* rtl/bb3_pkg.sv */
// ----------------------------------------------------------------------------
// bb3_pkg
// Types, constants and helpers shared by the 3x3 box blur modules.
// ----------------------------------------------------------------------------
package bb3_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 4096;

   localparam int FW_BITS        = 11;
   localparam int FH_BITS        = 13;
   localparam int CSR_DATA_BITS  = 13;
   localparam int CSR_INDEX_BITS = 2;
   localparam int PIX_BITS       = 8;
   localparam int ROW_BITS       = 12;
   localparam int COL_BITS       = 10;
   localparam int SUM_BITS       = 12;
   localparam int RECIP_BITS     = 17;
   localparam int RECIP_SHIFT    = 16;
   localparam int CNT_BITS       = 4;

   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;

   localparam logic [FW_BITS-1:0] FRAME_WIDTH_RESET  = 11'd1024;
   localparam logic [FH_BITS-1:0] FRAME_HEIGHT_RESET = 13'd768;

   typedef logic [3*PIX_BITS-1:0] pixel_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SUM,
      ST_MUL
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic       accept;
      logic       load;
      logic       sum;
      logic       put;
      logic [1:0] slot;   // bit 1: column offset, bit 0: row offset
      logic       last;
   } cmd_type;

   // datapath -> controller, position of the incoming pixel
   typedef struct packed {
      logic c_ge1;
      logic r_ge1;
      logic lastcol;
      logic lastrow;
   } status_type;

   // reciprocal * 2^16, exact for sums up to 9*255
   function automatic logic [RECIP_BITS-1:0] recip(input logic [CNT_BITS-1:0] n);
      logic [RECIP_BITS-1:0] r;
      case (n)
         4'd1:    r = 17'd65536;
         4'd2:    r = 17'd32768;
         4'd3:    r = 17'd21846;
         4'd4:    r = 17'd16384;
         4'd6:    r = 17'd10923;
         4'd9:    r = 17'd7282;
         default: r = 17'd65536;
      endcase
      return r;
   endfunction

endpackage

/* rtl/bb3_ctrl.sv */
// ----------------------------------------------------------------------------
// bb3_ctrl
// Sequencer: takes one pixel, then walks its pending results one by one.
// ----------------------------------------------------------------------------
module bb3_ctrl import bb3_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type  state_ff, state_in;
   logic [3:0] mask_ff, mask_in;
   logic       rsp_valid_ff, rsp_valid_in;

   logic       accept;
   logic       out_free;
   logic [1:0] slot;
   logic [3:0] slot_bit;
   logic [3:0] remain;

   assign accept   = (state_ff == ST_IDLE) && req_valid;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // lowest pending result first
   always_comb begin
      slot = 2'd0;
      if (mask_ff[0])      slot = 2'd0;
      else if (mask_ff[1]) slot = 2'd1;
      else if (mask_ff[2]) slot = 2'd2;
      else                 slot = 2'd3;
   end

   assign slot_bit = 4'b0001 << slot;
   assign remain   = mask_ff & ~slot_bit;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_LOAD;
         ST_LOAD: state_in = (mask_ff != 4'd0) ? ST_SUM : ST_IDLE;
         ST_SUM:  state_in = ST_MUL;
         ST_MUL: begin
            if (out_free) state_in = (remain != 4'd0) ? ST_SUM : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      cmd.accept = accept;
      cmd.load   = (state_ff == ST_LOAD);
      cmd.sum    = (state_ff == ST_SUM);
      cmd.put    = (state_ff == ST_MUL) && out_free;
      cmd.slot   = slot;
      cmd.last   = (remain == 4'd0);
   end

   always_comb begin
      mask_in = mask_ff;
      if (accept) begin
         mask_in = {status.lastcol & status.lastrow, status.lastcol & status.r_ge1,
                    status.c_ge1 & status.lastrow, status.c_ge1 & status.r_ge1};
      end else if (cmd.put) begin
         mask_in = remain;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.put)                        rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mask_ff      <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/bb3_datapath.sv */
// ----------------------------------------------------------------------------
// bb3_datapath
// Line stores, window, position counters, sums and reciprocal divide.
// ----------------------------------------------------------------------------
module bb3_datapath import bb3_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data,
   input  logic [PIX_BITS-1:0]       req_red_in,
   input  logic [PIX_BITS-1:0]       req_green_in,
   input  logic [PIX_BITS-1:0]       req_blue_in,
   output logic [PIX_BITS-1:0]       rsp_red_out,
   output logic [PIX_BITS-1:0]       rsp_green_out,
   output logic [PIX_BITS-1:0]       rsp_blue_out,
   output logic [ROW_BITS-1:0]       rsp_out_row,
   output logic [COL_BITS-1:0]       rsp_out_col,
   output logic                      rsp_run_last,
   output logic                      rsp_frame_done,
   input  cmd_type                   cmd,
   output status_type                status
);

   localparam int CW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   // configuration
   logic [FW_BITS-1:0] frame_width_ff;
   logic [FH_BITS-1:0] frame_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_FRAME_WIDTH:  frame_width_ff  <= csr_write_data[FW_BITS-1:0];
            REG_FRAME_HEIGHT: frame_height_ff <= csr_write_data[FH_BITS-1:0];
            default: ;
         endcase
      end
   end

   // clamped dimensions and position
   logic [31:0]   w_full, h_full;
   logic [CW-1:0] wm1, c_cl;
   logic [RW-1:0] hm1, r_cl;
   logic [CW-1:0] col_cnt_ff;
   logic [RW-1:0] row_cnt_ff;

   always_comb begin
      if (frame_width_ff == '0)                     w_full = 32'd1;
      else if (32'(frame_width_ff) > 32'(MAX_WIDTH)) w_full = 32'(MAX_WIDTH);
      else                                          w_full = 32'(frame_width_ff);
      if (frame_height_ff == '0)                      h_full = 32'd1;
      else if (32'(frame_height_ff) > 32'(MAX_HEIGHT)) h_full = 32'(MAX_HEIGHT);
      else                                            h_full = 32'(frame_height_ff);
   end

   assign wm1  = CW'(w_full - 32'd1);
   assign hm1  = RW'(h_full - 32'd1);
   assign c_cl = (col_cnt_ff < wm1) ? col_cnt_ff : wm1;
   assign r_cl = (row_cnt_ff < hm1) ? row_cnt_ff : hm1;

   assign status.c_ge1   = (c_cl != '0);
   assign status.r_ge1   = (r_cl != '0);
   assign status.lastcol = (c_cl == wm1);
   assign status.lastrow = (r_cl == hm1);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
      end else if (cmd.accept) begin
         if (status.lastcol) begin
            col_cnt_ff <= '0;
            row_cnt_ff <= status.lastrow ? '0 : RW'(32'(r_cl) + 32'd1);
         end else begin
            col_cnt_ff <= CW'(32'(c_cl) + 32'd1);
            row_cnt_ff <= r_cl;
         end
      end
   end

   // latched item
   pixel_type     pix_ff;
   logic [CW-1:0] c_ff;
   logic [RW-1:0] r_ff;
   logic          c_ge1_ff, c_ge2_ff, r_ge1_ff, r_ge2_ff, lastcol_ff, lastrow_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pix_ff     <= {req_red_in, req_green_in, req_blue_in};
         c_ff       <= c_cl;
         r_ff       <= r_cl;
         c_ge1_ff   <= status.c_ge1;
         r_ge1_ff   <= status.r_ge1;
         c_ge2_ff   <= (32'(c_cl) >= 32'd2);
         r_ge2_ff   <= (32'(r_cl) >= 32'd2);
         lastcol_ff <= status.lastcol;
         lastrow_ff <= status.lastrow;
      end
   end

   // line stores: read at accept, written back in the next cycle
   pixel_type older_mem [MAX_WIDTH];
   pixel_type newer_mem [MAX_WIDTH];
   pixel_type top_rd_ff, mid_rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) top_rd_ff <= older_mem[c_cl];
      if (cmd.load)   older_mem[c_ff] <= mid_rd_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) mid_rd_ff <= newer_mem[c_cl];
      if (cmd.load)   newer_mem[c_ff] <= pix_ff;
   end

   // window: [0..2] column c-1, [3..5] column c-2; rows top, mid, bottom
   pixel_type win_ff [6];
   pixel_type nb_ff  [3][3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) win_ff[i] <= '0;
      end else if (cmd.load) begin
         win_ff[3] <= win_ff[0];
         win_ff[4] <= win_ff[1];
         win_ff[5] <= win_ff[2];
         win_ff[0] <= top_rd_ff;
         win_ff[1] <= mid_rd_ff;
         win_ff[2] <= pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         nb_ff[0][0] <= win_ff[3]; nb_ff[1][0] <= win_ff[4]; nb_ff[2][0] <= win_ff[5];
         nb_ff[0][1] <= win_ff[0]; nb_ff[1][1] <= win_ff[1]; nb_ff[2][1] <= win_ff[2];
         nb_ff[0][2] <= top_rd_ff; nb_ff[1][2] <= mid_rd_ff; nb_ff[2][2] <= pix_ff;
      end
   end

   // neighborhood sums for the selected result
   logic                dr, dc;
   logic [2:0]          rm, cm;
   logic [1:0]          rcnt, ccnt;
   logic [CNT_BITS-1:0] n_sel;
   logic [SUM_BITS-1:0] sum_c [3];

   assign dr    = cmd.slot[0];
   assign dc    = cmd.slot[1];
   assign rm    = {1'b1, r_ge1_ff, !dr && r_ge2_ff};
   assign cm    = {1'b1, c_ge1_ff, !dc && c_ge2_ff};
   assign rcnt  = {1'b0, rm[0]} + {1'b0, rm[1]} + {1'b0, rm[2]};
   assign ccnt  = {1'b0, cm[0]} + {1'b0, cm[1]} + {1'b0, cm[2]};
   assign n_sel = {2'b00, rcnt} * {2'b00, ccnt};

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         sum_c[ch] = '0;
         for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
               if (rm[j] && cm[k]) begin
                  sum_c[ch] = sum_c[ch]
                            + SUM_BITS'(nb_ff[j][k][PIX_BITS*(2-ch) +: PIX_BITS]);
               end
            end
         end
      end
   end

   logic [SUM_BITS-1:0]   sum_ff [3];
   logic [RECIP_BITS-1:0] recip_ff;
   logic [ROW_BITS-1:0]   row_ff;
   logic [COL_BITS-1:0]   col_ff;
   logic                  last_ff, done_ff;

   always_ff @(posedge clock) begin
      if (cmd.sum) begin
         for (int ch = 0; ch < 3; ch++) sum_ff[ch] <= sum_c[ch];
         recip_ff <= recip(n_sel);
         row_ff   <= ROW_BITS'(32'(r_ff) + 32'(dr) - 32'd1);
         col_ff   <= COL_BITS'(32'(c_ff) + 32'(dc) - 32'd1);
         last_ff  <= cmd.last;
         done_ff  <= cmd.last && lastrow_ff && lastcol_ff;
      end
   end

   // divide by reciprocal multiply, straight into the output register
   logic [SUM_BITS+RECIP_BITS-1:0] prod [3];

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         prod[ch] = (SUM_BITS+RECIP_BITS)'(sum_ff[ch]) * (SUM_BITS+RECIP_BITS)'(recip_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.put) begin
         rsp_red_out    <= prod[0][RECIP_SHIFT +: PIX_BITS];
         rsp_green_out  <= prod[1][RECIP_SHIFT +: PIX_BITS];
         rsp_blue_out   <= prod[2][RECIP_SHIFT +: PIX_BITS];
         rsp_out_row    <= row_ff;
         rsp_out_col    <= col_ff;
         rsp_run_last   <= last_ff;
         rsp_frame_done <= done_ff;
      end
   end

endmodule

/* rtl/box_blur_3x3_edge_average.sv */
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_average
// 3x3 box blur over a raster-order RGB pixel stream, edge-aware averaging.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries one pixel item in raster order; taken when req_valid is
//    high and req_stall low. rsp_* carries blurred items with row/column.
//  - The result for (row-1, col-1) appears after pixel (row, col); the last
//    column and last row flush, so one pixel yields 0 to 4 result items,
//    left column first, upper row first in each. run_last marks the last
//    item of a pixel, frame_done the last item of the frame.
//  - Steps: a pixel passes an accept step and a load step (line store
//    read/write back), then each result a sum and a reciprocal multiply step.
//    The line store read port and the shared sum/multiply unit set this.
//    The first result reaches the output register at its multiply step.
//  - The next pixel is taken while the last result still waits in the
//    output register.
//  - Receiver stall: the output register holds; the sequencer waits in
//    its multiply step until the register frees.
//  - Reset (synchronous): counters, window and control clear; frame size
//    returns to 1024 x 768. Line stores are not cleared (no clearing
//    pass); unwritten entries only ever feed out-of-frame rows.
//  - csr_* writes frame_width (index 0) and frame_height (index 1) while idle.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_average import bb3_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                      clock,
   input  logic                      reset,
   // configuration
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data,
   // pixel in
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [PIX_BITS-1:0]       req_red_in,
   input  logic [PIX_BITS-1:0]       req_green_in,
   input  logic [PIX_BITS-1:0]       req_blue_in,
   // blurred pixel out
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [PIX_BITS-1:0]       rsp_red_out,
   output logic [PIX_BITS-1:0]       rsp_green_out,
   output logic [PIX_BITS-1:0]       rsp_blue_out,
   output logic [ROW_BITS-1:0]       rsp_out_row,
   output logic [COL_BITS-1:0]       rsp_out_col,
   output logic                      rsp_run_last,
   output logic                      rsp_frame_done
);

   cmd_type    cmd;
   status_type status;

   // sequencer: one pixel at a time, its results one by one
   bb3_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // storage and arithmetic
   bb3_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_red_in       (req_red_in),
      .req_green_in     (req_green_in),
      .req_blue_in      (req_blue_in),
      .rsp_red_out      (rsp_red_out),
      .rsp_green_out    (rsp_green_out),
      .rsp_blue_out     (rsp_blue_out),
      .rsp_out_row      (rsp_out_row),
      .rsp_out_col      (rsp_out_col),
      .rsp_run_last     (rsp_run_last),
      .rsp_frame_done   (rsp_frame_done),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

/* rtl/bb3_checker.sv */
// ----------------------------------------------------------------------------
// bb3_checker
// Port-level checks for the box blur, bound to the top level.
// ----------------------------------------------------------------------------
`include "box_blur_3x3_edge_average_defines.svh"

module bb3_checker import bb3_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_run_last,
   input logic rsp_frame_done
);

   // stalled result stays offered
   `BB3_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid)
   // frame end is always the last item of its pixel
   `BB3_ASSERT(a_done_is_last, rsp_valid && rsp_frame_done |-> rsp_run_last)
   // one pixel in flight: busy right after a take
   `BB3_ASSERT(a_busy_after_take, req_valid && !req_stall |=> req_stall)
   // reset leaves the block ready with nothing to show
   `BB3_ASSERT_ALWAYS(a_reset_clean, reset |=> !rsp_valid && !req_stall)

endmodule

bind box_blur_3x3_edge_average bb3_checker u_bb3_checker (.*);
